/* sv/ecu_pkg.sv */
// Package for the easing curve unit: curve mode codes, register indexes, fixed-point format.
// No dependencies.
`default_nettype none
package ecu_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned TimeW    = 17;
  localparam int unsigned OutW     = 20;
  localparam int unsigned ModeW    = 4;
  localparam int unsigned FracBits = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CURVE_MODE = 3'd0,
    REG_BEZIER_C0  = 3'd1,
    REG_BEZIER_C1  = 3'd2,
    REG_BEZIER_C2  = 3'd3,
    REG_BEZIER_C3  = 3'd4
  } reg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_BEZIER    = 4'd0,
    MODE_QUAD_IN   = 4'd1,
    MODE_QUAD_OUT  = 4'd2,
    MODE_QUAD_IO   = 4'd3,
    MODE_QUART_IN  = 4'd4,
    MODE_QUART_OUT = 4'd5,
    MODE_QUART_IO  = 4'd6,
    MODE_QUINT_IN  = 4'd7,
    MODE_QUINT_OUT = 4'd8,
    MODE_QUINT_IO  = 4'd9,
    MODE_CIRC_IN   = 4'd10,
    MODE_CIRC_OUT  = 4'd11,
    MODE_CIRC_IO   = 4'd12,
    MODE_CUBIC_IN  = 4'd13,
    MODE_CUBIC_OUT = 4'd14,
    MODE_CUBIC_IO  = 4'd15
  } curve_mode_e;

  // Curve family and form, decoded from the mode
  typedef enum logic [2:0] {
    FAM_BEZIER = 3'd0,
    FAM_POW    = 3'd1,
    FAM_CIRCLE = 3'd2
  } family_e;

  typedef enum logic [1:0] {
    FORM_IN  = 2'd0,
    FORM_OUT = 2'd1,
    FORM_IO  = 2'd2
  } form_e;

  typedef struct packed {
    family_e     family;
    form_e       form;
    logic [2:0]  n;
  } curve_ctl_t;

  function automatic curve_ctl_t decode_mode(input logic [ModeW-1:0] m);
    curve_ctl_t c;
    c.family = FAM_POW;
    c.form   = FORM_IN;
    c.n      = 3'd2;
    unique case (curve_mode_e'(m))
      MODE_BEZIER:    c.family = FAM_BEZIER;
      MODE_QUAD_IN:   c.n = 3'd2;
      MODE_QUAD_OUT:  begin c.n = 3'd2; c.form = FORM_OUT; end
      MODE_QUAD_IO:   begin c.n = 3'd2; c.form = FORM_IO;  end
      MODE_QUART_IN:  c.n = 3'd4;
      MODE_QUART_OUT: begin c.n = 3'd4; c.form = FORM_OUT; end
      MODE_QUART_IO:  begin c.n = 3'd4; c.form = FORM_IO;  end
      MODE_QUINT_IN:  c.n = 3'd5;
      MODE_QUINT_OUT: begin c.n = 3'd5; c.form = FORM_OUT; end
      MODE_QUINT_IO:  begin c.n = 3'd5; c.form = FORM_IO;  end
      MODE_CIRC_IN:   begin c.family = FAM_CIRCLE; end
      MODE_CIRC_OUT:  begin c.family = FAM_CIRCLE; c.form = FORM_OUT; end
      MODE_CIRC_IO:   begin c.family = FAM_CIRCLE; c.form = FORM_IO;  end
      MODE_CUBIC_IN:  c.n = 3'd3;
      MODE_CUBIC_OUT: begin c.n = 3'd3; c.form = FORM_OUT; end
      MODE_CUBIC_IO:  begin c.n = 3'd3; c.form = FORM_IO;  end
      default:        c.family = FAM_POW;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/ecu_if.sv */
// Valid/ready channel interfaces for the easing curve unit.
// Depends on ecu_pkg for field widths.
`default_nettype none
interface ecu_in_if;
  logic                        valid;
  logic                        ready;
  logic [ecu_pkg::TimeW-1:0]   time_in;
  modport source (output valid, time_in, input ready);
  modport sink   (input valid, time_in, output ready);
endinterface

interface ecu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ecu_pkg::OutW-1:0]   eased_value;
  logic                              saturated;
  modport source (output valid, eased_value, saturated, input ready);
  modport sink   (input valid, eased_value, saturated, output ready);
endinterface

interface ecu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ecu_pkg::CfgIdxW-1:0]   index;
  logic [ecu_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/ecu_mul.sv */
// Signed fixed-point multiply stage: registered product, shifted right by SH
// with rounding, ties away from zero. Depends on nothing.
`default_nettype none
module ecu_mul #(
  parameter int unsigned AW = 20,
  parameter int unsigned BW = 20,
  parameter int unsigned SH = 16,
  parameter int unsigned RW = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [RW-1:0]      p_o
);
  localparam int unsigned PW = AW + BW;

  logic signed [PW-1:0] prod;
  logic [PW-1:0]        mag;
  logic [PW-1:0]        rnd;
  logic signed [RW-1:0] p_d;
  logic signed [RW-1:0] p_q;

  // Round magnitude, restore sign
  always_comb begin
    prod = a_i * b_i;
    mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
    rnd  = (mag + (PW'(1) << (SH - 1))) >> SH;
    p_d  = prod[PW-1] ? RW'(-$signed(rnd)) : RW'($signed(rnd));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

/* sv/ecu_sqrt_stage.sv */
// One registered stage of the digit-by-digit integer square root (up to STEPS
// result bits per stage). Depends on nothing.
`default_nettype none
module ecu_sqrt_stage #(
  parameter int unsigned W     = 36,
  parameter int unsigned STEPS = 3,
  parameter int unsigned FIRST = 17
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] n_i,
  input  wire logic [W-1:0] r_i,
  output logic [W-1:0]      n_o,
  output logic [W-1:0]      r_o
);
  logic [W-1:0] n_d, r_d, n_q, r_q, b;

  // Run this stage's bit positions, highest first
  always_comb begin
    n_d = n_i;
    r_d = r_i;
    b   = '0;
    for (int i = 0; i < STEPS; i++) begin
      if (FIRST >= i) begin
        b = W'(1) << (2 * (FIRST - i));
        if (n_d >= r_d + b) begin
          n_d = n_d - (r_d + b);
          r_d = (r_d >> 1) + b;
        end else begin
          r_d = r_d >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign n_o = n_q;
  assign r_o = r_q;
endmodule
`default_nettype wire

/* sv/easing_curve_unit.sv */
// Top level of the easing curve unit: config registers, datapath pipeline, output register.
// Depends on ecu_pkg, ecu_if, ecu_mul and ecu_sqrt_stage.
//
//  channel   dir  handshake     payload
//  in_if     in   valid/ready   time_in [16:0]
//  out_if    out  valid/ready   eased_value [19:0] signed, saturated
//  cfg_if    in   valid/ready   index [2:0], data [19:0]
//
// One sample per clock while the output is not stalled; from acceptance to the
// output register a sample passes the input stage, four multiply stages of the
// power chain, the power result stage, six square root stages and the output stage.
// Reset clears valid bits and restores register defaults.
// A stall at the output freezes the whole pipeline; the input is ready while
// the output register is empty or being emptied.
`default_nettype none
module easing_curve_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ecu_in_if.sink    in_if,
  ecu_out_if.source out_if,
  ecu_cfg_if.sink   cfg_if
);
  import ecu_pkg::*;

  localparam logic signed [23:0] One = 24'sd1 <<< FracBits;
  localparam int unsigned VW = 24;            // internal signed value width
  localparam int unsigned SW = 2 * VW;        // sqrt work width
  localparam int unsigned SqTop = (VW + FracBits) / 2;
  localparam int unsigned NSq = 6;
  localparam int unsigned SqSteps = (SqTop + NSq) / NSq;
  localparam int unsigned Lat = 12;           // stages ahead of the output register

  // ---------------- configuration registers
  logic [ModeW-1:0]           mode_q;
  logic signed [CfgDataW-1:0] c0_q, c1_q, c2_q, c3_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeW'(MODE_QUAD_IN);
      c0_q   <= '0;
      c1_q   <= '0;
      c2_q   <= CfgDataW'(65536);
      c3_q   <= CfgDataW'(65536);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_CURVE_MODE: mode_q <= cfg_if.data[ModeW-1:0];
        REG_BEZIER_C0:  c0_q   <= cfg_if.data;
        REG_BEZIER_C1:  c1_q   <= cfg_if.data;
        REG_BEZIER_C2:  c2_q   <= cfg_if.data;
        REG_BEZIER_C3:  c3_q   <= cfg_if.data;
        default:        ;
      endcase
    end
  end

  curve_ctl_t ctl;
  assign ctl = decode_mode(mode_q);

  // ---------------- pipeline control
  logic             adv;
  logic [Lat-1:0]   vld_q;
  logic             out_vld_q;

  assign adv         = !out_vld_q || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Lat-2:0], in_if.valid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  // ---------------- stage 0: clamp time, form bases
  logic signed [VW-1:0] t_q, base_q, u_q;
  logic                 lo_q;
  logic signed [VW-1:0] t_c, s_c;

  always_comb begin
    t_c = (VW'(in_if.time_in) > One) ? One : VW'(in_if.time_in);
    s_c = t_c <<< 1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q  <= t_c;
      u_q  <= One - t_c;
      lo_q <= (s_c < One);
      unique case (ctl.form)
        FORM_IN:  base_q <= t_c;
        FORM_OUT: base_q <= t_c - One;
        default:  base_q <= (s_c < One) ? s_c : s_c - (One <<< 1);
      endcase
    end
  end

  // ---------------- stages 1-4: power chain p_k = base^min(k,n), p1 = base
  logic signed [VW-1:0] bd [1:5];
  logic                 lod [1:5];
  logic signed [VW-1:0] td [1:5];
  logic signed [VW-1:0] ud [1:5];
  logic signed [VW-1:0] pk_q [1:5];  // pk_q[k] holds base^n truncated at step k
  logic signed [VW-1:0] p2_q [2:5];  // base^2 kept for circle

  assign bd[1]  = base_q;
  assign lod[1] = lo_q;
  assign td[1]  = t_q;
  assign ud[1]  = u_q;
  assign pk_q[1] = base_q;

  for (genvar k = 2; k <= 5; k++) begin : g_pow
    logic signed [VW-1:0] prev;
    logic signed [VW-1:0] nxt;
    assign prev = (k == 2) ? base_q : pk_q[k-1];
    ecu_mul #(.AW(VW), .BW(VW), .SH(FracBits), .RW(VW)) u_pm (
      .clk_i, .en_i(adv), .a_i(prev), .b_i(bd[k-1]), .p_o(nxt)
    );
    logic signed [VW-1:0] keep_q, b_q, t2_q, u2_q;
    logic                 lo2_q;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        keep_q <= prev;
        b_q    <= bd[k-1];
        lo2_q  <= lod[k-1];
        t2_q   <= td[k-1];
        u2_q   <= ud[k-1];
      end
    end
    // stop multiplying once the exponent is reached
    assign pk_q[k] = (ctl.n >= 3'(k)) ? nxt : keep_q;
    assign bd[k]   = b_q;
    assign lod[k]  = lo2_q;
    assign td[k]   = t2_q;
    assign ud[k]   = u2_q;
    if (k == 2) begin : g_sq
      assign p2_q[2] = nxt;
    end else begin : g_sqd
      logic signed [VW-1:0] p2d_q;
      always_ff @(posedge clk_i) if (adv) p2d_q <= p2_q[k-1];
      assign p2_q[k] = p2d_q;
    end
  end

  // ---------------- bezier weights (parallel, stages 1-2)
  logic signed [VW-1:0] u2, t2, w0, t_u2, t2_u, w3;
  ecu_mul #(.AW(VW), .BW(VW), .SH(FracBits), .RW(VW)) u_u2 (
    .clk_i, .en_i(adv), .a_i(u_q), .b_i(u_q), .p_o(u2));
  ecu_mul #(.AW(VW), .BW(VW), .SH(FracBits), .RW(VW)) u_t2 (
    .clk_i, .en_i(adv), .a_i(t_q), .b_i(t_q), .p_o(t2));
  ecu_mul #(.AW(VW), .BW(VW), .SH(FracBits), .RW(VW)) u_w0 (
    .clk_i, .en_i(adv), .a_i(u2), .b_i(ud[2]), .p_o(w0));
  ecu_mul #(.AW(VW), .BW(VW), .SH(FracBits), .RW(VW)) u_w1 (
    .clk_i, .en_i(adv), .a_i(td[2]), .b_i(u2), .p_o(t_u2));
  ecu_mul #(.AW(VW), .BW(VW), .SH(FracBits), .RW(VW)) u_w2 (
    .clk_i, .en_i(adv), .a_i(t2), .b_i(ud[2]), .p_o(t2_u));
  ecu_mul #(.AW(VW), .BW(VW), .SH(FracBits), .RW(VW)) u_w3 (
    .clk_i, .en_i(adv), .a_i(t2), .b_i(td[2]), .p_o(w3));

  // stage 3: weight times control value, registered
  localparam int unsigned TW = VW + CfgDataW + 2;
  logic signed [TW-1:0] m0_q, m1_q, m2_q, m3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m0_q <= TW'(w0 * c0_q);
      m1_q <= TW'((t_u2 * 3) * c1_q);
      m2_q <= TW'((t2_u * 3) * c2_q);
      m3_q <= TW'(w3 * c3_q);
    end
  end
  // stage 4: exact sum and rounding
  localparam int unsigned AccW = TW + 2;
  logic signed [AccW-1:0] acc;
  logic [AccW-1:0]        amag, arnd;
  logic signed [VW+4:0]   bez_q;
  always_comb begin
    acc  = AccW'(m0_q) + AccW'(m1_q) + AccW'(m2_q) + AccW'(m3_q);
    amag = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    arnd = (amag + (AccW'(1) << (FracBits - 1))) >> FracBits;
  end
  always_ff @(posedge clk_i) begin
    if (adv) bez_q <= acc[AccW-1] ? (VW+5)'(-$signed(arnd)) : (VW+5)'($signed(arnd));
  end

  // ---------------- stage 5: power result and circle radicand
  logic signed [VW+1:0] pres_q;
  logic [SW-1:0]        rad_q;
  logic                 lo6_q;
  logic signed [VW+4:0] bez6_q;
  logic signed [VW+1:0] half;
  logic signed [VW-1:0] p2v;
  always_comb begin
    half = ctl.form == FORM_IO ? (VW+2)'(pk_q[5] >>> 1) + (VW+2)'(pk_q[5] & 1)
                               : (VW+2)'(pk_q[5]);
    if (ctl.form == FORM_IO && pk_q[5] < 0) begin
      half = -((VW+2)'((-pk_q[5]) >>> 1) + (VW+2)'((-pk_q[5]) & 1));
    end
    p2v = p2_q[5];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo6_q  <= lod[5];
      bez6_q <= bez_q;
      // in form takes the power as is, the lower half of in-out takes half of it
      if (ctl.form == FORM_IN || (ctl.form == FORM_IO && lod[5])) begin
        pres_q <= half;
      end else begin
        pres_q <= ctl.n[0] ? (VW+2)'(One) + half : (VW+2)'(One) - half;
      end
      if (ctl.form == FORM_IN) begin
        rad_q <= (One - p2v > 0) ? SW'(One - p2v) << FracBits : '0;
      end else begin
        rad_q <= (One - p2v > 0) ? SW'(One - p2v) << FracBits : '0;
      end
    end
  end

  // ---------------- stages 6-11: square root
  logic [SW-1:0] sn [0:NSq];
  logic [SW-1:0] sr [0:NSq];
  logic signed [VW+1:0] pr_d [0:NSq];
  logic signed [VW+4:0] bz_d [0:NSq];
  logic                 lo_d [0:NSq];
  assign sn[0] = rad_q;
  assign sr[0] = '0;
  assign pr_d[0] = pres_q;
  assign bz_d[0] = bez6_q;
  assign lo_d[0] = lo6_q;
  for (genvar j = 0; j < NSq; j++) begin : g_sq
    ecu_sqrt_stage #(.W(SW), .STEPS(SqSteps), .FIRST(SqTop - j * SqSteps)) u_st (
      .clk_i, .en_i(adv), .n_i(sn[j]), .r_i(sr[j]), .n_o(sn[j+1]), .r_o(sr[j+1]));
    logic signed [VW+1:0] pr_q;
    logic signed [VW+4:0] bz_q;
    logic                 l_q;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pr_q <= pr_d[j];
        bz_q <= bz_d[j];
        l_q  <= lo_d[j];
      end
    end
    assign pr_d[j+1] = pr_q;
    assign bz_d[j+1] = bz_q;
    assign lo_d[j+1] = l_q;
  end

  // ---------------- stage 12: select, clip, output register
  logic signed [VW+4:0] res;
  logic signed [VW+4:0] sq;
  logic signed [VW+4:0] cv;
  logic signed [VW+4:0] cm;
  always_comb begin
    sq = (VW+5)'(sr[NSq]);
    unique case (ctl.form)
      FORM_IN:  cv = (VW+5)'(One) - sq;
      FORM_OUT: cv = sq;
      default:  cv = lo_d[NSq] ? (VW+5)'(One) - sq : (VW+5)'(One) + sq;
    endcase
    cm = ((ctl.form == FORM_IO) ? ((cv >>> 1) + (VW+5)'(cv & 1)) : cv);
    unique case (ctl.family)
      FAM_BEZIER: res = bz_d[NSq];
      FAM_CIRCLE: res = cm;
      default:    res = (VW+5)'(pr_d[NSq]);
    endcase
  end

  logic signed [OutW-1:0] val_q;
  logic                   sat_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (res > (VW+5)'(524287)) begin
        val_q <= OutW'(524287);
        sat_q <= 1'b1;
      end else if (res < -(VW+5)'(524288)) begin
        val_q <= OutW'(-524288);
        sat_q <= 1'b1;
      end else begin
        val_q <= OutW'(res);
        sat_q <= 1'b0;
      end
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.eased_value = val_q;
  assign out_if.saturated   = sat_q;

  // ---------------- assertions
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_if.ready |=> $stable(vld_q))
    else $error("pipeline moved during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_if.ready)
    else $error("input blocked with empty output");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_if.saturated |->
      (out_if.eased_value == OutW'(524287) || out_if.eased_value == OutW'(-524288)))
    else $error("saturation flag without clipped value");
endmodule
`default_nettype wire
